### sv/frac_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frac_pkg;

    // Operand width and derived widths
    localparam int DATA_WIDTH = 32;
    localparam int MAG_W      = DATA_WIDTH - 1;
    localparam int SHIFT_W    = $clog2(MAG_W);
    localparam int CNT_W      = $clog2(MAG_W + 1);

    typedef logic [MAG_W-1:0] mag_t;

    // Input item
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] numerator;
        logic signed [DATA_WIDTH-1:0] denominator;
    } frac_in_t;

    // Result item
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] reduced_numerator;
        logic [MAG_W-1:0]             reduced_denominator;
        logic                         zero_denominator;
    } frac_out_t;

    // Request to the shared divider
    typedef struct packed {
        logic go;
        mag_t dividend;
        mag_t divisor;
    } div_req_t;

    // Status back from the shared divider
    typedef struct packed {
        logic done;
        mag_t quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

### sv/frac_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider: one quotient bit per cycle.
// The divisor must stay stable while a divide runs.
module frac_div
    import frac_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic             run_reg,  run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    mag_t             rem_reg,  rem_next;
    mag_t             quo_reg,  quo_next;

    logic [MAG_W:0]   trial;
    logic [MAG_W+1:0] diff;
    logic             fits;

    // Shift in next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[MAG_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, req.divisor};
    assign fits  = ~diff[MAG_W+1];

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.go)
        begin
            run_next = 1'b1;
            cnt_next = CNT_W'(MAG_W);
            rem_next = '0;
            quo_next = req.dividend;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
            quo_next = {quo_reg[MAG_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

### sv/fraction_reducer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Fraction reducer: one fraction in, one reduced fraction out.
// Zero numerator or zero denominator: result and done are registered in the cycle after the transfer.
// Otherwise the binary GCD subtract/shift loop runs, then the one-bit divider runs once per
// fraction part, numerator first, then denominator.
// A new fraction is taken only while idle; busy is high from transfer to result, but the zero cases never leave idle.
// Reset: rst_n asynchronous, active low; clears sequencer and done; the receiver cannot stall.
module fraction_reducer_unit
    import frac_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire frac_in_t operand,
    output logic          done,
    output frac_out_t     result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_GCD  = 4'b0010,
        ST_DIVN = 4'b0100,
        ST_DIVD = 4'b1000
    } state_t;

    state_t             state_reg,  state_next;
    logic               done_reg,   done_next;
    logic               go_reg,     go_next;
    frac_out_t          result_reg, result_next;
    mag_t               nmag_reg,   nmag_next;
    mag_t               dmag_reg,   dmag_next;
    logic               neg_reg,    neg_next;
    mag_t               a_reg,      a_next;
    mag_t               b_reg,      b_next;
    logic [SHIFT_W-1:0] k_reg,      k_next;
    mag_t               g_reg,      g_next;
    mag_t               qn_reg,     qn_next;

    mag_t               in_nmag;
    mag_t               in_dmag;
    mag_t               a_minus_b;
    mag_t               b_minus_a;
    logic               a_ge_b;
    logic [DATA_WIDTH-1:0] qn_wide;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // Sign split with saturation of the most negative code
    function automatic mag_t sat_mag(input logic [DATA_WIDTH-1:0] v);
        logic [DATA_WIDTH-1:0] m;
        m = v[DATA_WIDTH-1] ? (~v + DATA_WIDTH'(1)) : v;
        if (m[DATA_WIDTH-1])
            return {MAG_W{1'b1}};
        return m[MAG_W-1:0];
    endfunction

    assign in_nmag = sat_mag(operand.numerator);
    assign in_dmag = sat_mag(operand.denominator);

    // GCD comparator and subtractors
    assign a_ge_b    = (a_reg >= b_reg);
    assign a_minus_b = a_reg - b_reg;
    assign b_minus_a = b_reg - a_reg;

    assign qn_wide = {1'b0, qn_reg};

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        go_next     = 1'b0;
        result_next = result_reg;
        nmag_next   = nmag_reg;
        dmag_next   = dmag_reg;
        neg_next    = neg_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        g_next      = g_reg;
        qn_next     = qn_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    nmag_next = in_nmag;
                    dmag_next = in_dmag;
                    neg_next  = operand.numerator[DATA_WIDTH-1]
                              ^ operand.denominator[DATA_WIDTH-1];
                    a_next    = in_nmag;
                    b_next    = in_dmag;
                    k_next    = '0;
                    if (in_dmag == '0)
                    begin
                        result_next.reduced_numerator   = '0;
                        result_next.reduced_denominator = '0;
                        result_next.zero_denominator    = 1'b1;
                        done_next = 1'b1;
                    end
                    else if (in_nmag == '0)
                    begin
                        result_next.reduced_numerator   = '0;
                        result_next.reduced_denominator = MAG_W'(1);
                        result_next.zero_denominator    = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                // Binary GCD, one step per cycle; b stays nonzero
                if (a_reg == '0)
                begin
                    g_next     = b_reg << k_reg;
                    go_next    = 1'b1;
                    state_next = ST_DIVN;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + SHIFT_W'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (a_ge_b)
                begin
                    a_next = a_minus_b >> 1;
                end
                else
                begin
                    b_next = b_minus_a >> 1;
                end
            end
            ST_DIVN:
            begin
                if (div_rsp.done)
                begin
                    qn_next    = div_rsp.quotient;
                    go_next    = 1'b1;
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (div_rsp.done)
                begin
                    result_next.reduced_numerator   = neg_reg ? (~qn_wide + DATA_WIDTH'(1))
                                                              : qn_wide;
                    result_next.reduced_denominator = div_rsp.quotient;
                    result_next.zero_denominator    = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            go_reg    <= go_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        nmag_reg   <= nmag_next;
        dmag_reg   <= dmag_next;
        neg_reg    <= neg_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        k_reg      <= k_next;
        g_reg      <= g_next;
        qn_reg     <= qn_next;
    end

    // Shared divider: numerator first, then denominator
    assign div_req.go       = go_reg;
    assign div_req.dividend = (state_reg == ST_DIVD) ? dmag_reg : nmag_reg;
    assign div_req.divisor  = g_reg;

    frac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### dv/tb_fraction_reducer_unit.sv
`timescale 1ns / 1ps

module tb_fraction_reducer_unit
    import frac_pkg::*;
();

    localparam logic [DATA_WIDTH-1:0] MAX_MAG  = {1'b0, {MAG_W{1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {MAG_W{1'b0}}};

    // One directed row: the fraction, and a literal result where it is obvious
    typedef struct {
        frac_in_t  src;
        bit        literal;
        frac_out_t want;
    } dir_row_t;

    // One fraction in flight: what went in and what must come back
    typedef struct {
        frac_in_t  src;
        frac_out_t want;
    } pending_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    frac_in_t  operand = '0;
    logic      busy;
    logic      done;
    frac_out_t result;

    pending_t  pending_reductions[$];
    int        mismatch_count = 0;
    int        idle_pct = 0;

    logic [DATA_WIDTH-1:0] boundary_values [6] =
        '{'0, 1, -1, MAX_MAG, -MAX_MAG, MOST_NEG};

    fraction_reducer_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .done    (done),
        .result  (result)
    );

    // Clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #12_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Sign and magnitude of a field; the most negative code saturates
    function automatic mag_t saturated_magnitude(input logic [DATA_WIDTH-1:0] raw,
                                                 output bit neg);
        logic [DATA_WIDTH-1:0] absval;
        neg    = raw[DATA_WIDTH-1];
        absval = neg ? (~raw + 1'b1) : raw;
        if (absval[DATA_WIDTH-1])
            return {MAG_W{1'b1}};
        return absval[MAG_W-1:0];
    endfunction

    // Lowest terms by Euclid, sign moved onto the numerator
    function automatic frac_out_t predict_lowest_terms(input frac_in_t f);
        frac_out_t r;
        bit        nneg, dneg;
        mag_t      nmag, dmag, a, b, rem, qn, qd;
        nmag = saturated_magnitude(f.numerator, nneg);
        dmag = saturated_magnitude(f.denominator, dneg);
        r = '0;
        if (dmag == '0)
        begin
            r.zero_denominator = 1'b1;
            return r;
        end
        a = nmag;
        b = dmag;
        while (b != '0)
        begin
            rem = a % b;
            a   = b;
            b   = rem;
        end
        qn = nmag / a;
        qd = dmag / a;
        r.reduced_numerator = {1'b0, qn};
        if (qn != '0 && nneg != dneg)
            r.reduced_numerator = -r.reduced_numerator;
        r.reduced_denominator = qd;
        return r;
    endfunction

    function automatic dir_row_t drow(input logic [DATA_WIDTH-1:0] n, d,
                                      input bit lit,
                                      input logic [DATA_WIDTH-1:0] en,
                                      input logic [DATA_WIDTH-1:0] ed,
                                      input bit ez);
        dir_row_t r;
        r.src.numerator             = n;
        r.src.denominator           = d;
        r.literal                   = lit;
        r.want.reduced_numerator    = en;
        r.want.reduced_denominator  = ed[MAG_W-1:0];
        r.want.zero_denominator     = ez;
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] random_sign(input logic [DATA_WIDTH-1:0] m);
        return $urandom_range(1) ? -m : m;
    endfunction

    // Random fraction: pairs sharing a common factor, plus noise, small values, powers of two and corners
    function automatic frac_in_t random_fraction();
        frac_in_t    f;
        int unsigned a, b, k;
        int          sn, sd;
        case ($urandom_range(9)) inside
            0, 1:
                f = {$urandom, $urandom};
            2:
            begin
                f.numerator   = boundary_values[$urandom_range(5)];
                f.denominator = boundary_values[$urandom_range(5)];
            end
            3, 4:
            begin
                sn = $urandom_range(128);
                sd = $urandom_range(128);
                f.numerator   = sn - 64;
                f.denominator = sd - 64;
            end
            5, 6, 7:
            begin
                a = $urandom_range(65535, 1);
                b = $urandom_range(65535, 1);
                k = $urandom_range(32'h7fff_ffff / ((a > b) ? a : b), 1);
                f.numerator   = random_sign(a * k);
                f.denominator = random_sign(b * k);
            end
            8:
            begin
                f.numerator   = random_sign($urandom >> $urandom_range(31, 1));
                f.denominator = random_sign(32'd1 << $urandom_range(30));
            end
            default:
            begin
                f.numerator   = random_sign(MAX_MAG - $urandom_range(1000));
                f.denominator = random_sign(MAX_MAG - $urandom_range(1000));
            end
        endcase
        return f;
    endfunction

    // Offer one fraction until it transfers, idling at random per cycle
    task automatic send_fraction(input frac_in_t f, input bit lit, input frac_out_t lit_want);
        bit       accepted;
        pending_t p;
        accepted = 1'b0;
        while (!accepted)
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                start   <= 1'b0;
                operand <= {$urandom, $urandom};
            end
            else
            begin
                start   <= 1'b1;
                operand <= f;
            end
            @(posedge clk);
            accepted = start && !busy;
        end
        p.src  = f;
        p.want = lit ? lit_want : predict_lowest_terms(f);
        pending_reductions.push_back(p);
    endtask

    // Result checker: every strobe must match the oldest pending fraction
    always @(posedge clk)
    begin
        pending_t p;
        if (rst_n && done)
        begin
            if (pending_reductions.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %0d / %0d zero_den %0b",
                             result.reduced_numerator, result.reduced_denominator,
                             result.zero_denominator);
            end
            else
            begin
                p = pending_reductions.pop_front();
                if (result.reduced_numerator   !== p.want.reduced_numerator ||
                    result.reduced_denominator !== p.want.reduced_denominator ||
                    result.zero_denominator    !== p.want.zero_denominator)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch for %0d / %0d: ",
                                  "expected %0d / %0d z%0b, got %0d / %0d z%0b"},
                                 p.src.numerator, p.src.denominator,
                                 p.want.reduced_numerator, p.want.reduced_denominator,
                                 p.want.zero_denominator,
                                 result.reduced_numerator, result.reduced_denominator,
                                 result.zero_denominator);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        dir_row_t directed_rows[$];
        int       phase_idle[4];
        phase_idle = '{0, 73, 17, 0};

        // Zero cases, signs, full-scale magnitudes, saturation, deep Euclid chains
        directed_rows = '{
            drow(0, 1, 1, 0, 1, 0),
            drow(0, 0, 1, 0, 0, 1),
            drow(5, 0, 1, 0, 0, 1),
            drow(-7, 0, 1, 0, 0, 1),
            drow(MOST_NEG, 0, 1, 0, 0, 1),
            drow(0, -5, 1, 0, 1, 0),
            drow(6, 4, 0, 0, 0, 0),
            drow(-6, 4, 0, 0, 0, 0),
            drow(6, -4, 0, 0, 0, 0),
            drow(-6, -4, 0, 0, 0, 0),
            drow(1, 1, 1, 1, 1, 0),
            drow(-1, -1, 1, 1, 1, 0),
            drow(MAX_MAG, 1, 1, MAX_MAG, 1, 0),
            drow(-MAX_MAG, 1, 1, -MAX_MAG, 1, 0),
            drow(1, MAX_MAG, 1, 1, MAX_MAG, 0),
            drow(1, -MAX_MAG, 1, -1, MAX_MAG, 0),
            drow(MAX_MAG, MAX_MAG, 1, 1, 1, 0),
            drow(-MAX_MAG, MAX_MAG, 1, -1, 1, 0),
            drow(MOST_NEG, 1, 1, -MAX_MAG, 1, 0),
            drow(1, MOST_NEG, 1, -1, MAX_MAG, 0),
            drow(MOST_NEG, MOST_NEG, 1, 1, 1, 0),
            drow(2147483647, 2147483646, 0, 0, 0, 0),
            drow(1073741824, -536870912, 0, 0, 0, 0),
            drow(1836311903, 1134903170, 0, 0, 0, 0),
            drow(12345678, -87654321, 0, 0, 0, 0)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 0;
        foreach (directed_rows[i])
            send_fraction(directed_rows[i].src, directed_rows[i].literal,
                          directed_rows[i].want);

        // Random phases: back to back, mostly idle, lightly idle, back to back
        foreach (phase_idle[ph])
        begin
            idle_pct = phase_idle[ph];
            repeat (200)
                send_fraction(random_fraction(), 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_reductions.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
sv/frac_pkg.sv
sv/frac_div.sv
sv/fraction_reducer_unit.sv
dv/tb_fraction_reducer_unit.sv
